[rtl/core/swr_pkg.sv]
// Shared types, constants and microcode program for the VSWR sweep smoother.
package swr_pkg;

  localparam int IDX_W     = 6;
  localparam int VSWR_W    = 16;
  localparam int FREQ_W    = 33;
  localparam int CENTER_W  = 32;
  localparam int SPAN_W    = 20;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam int SUM_W     = 19;
  localparam int TAPS      = 5;

  localparam logic [VSWR_W-1:0]    ONE_Q88    = 16'd256;
  // floor(x / 5) == (x * 419431) >> 21 for every x below 2^19
  localparam logic [SUM_W-1:0]     DIV5_MUL   = 19'd419431;
  localparam int                   DIV5_SHIFT = 21;

  localparam logic [CENTER_W-1:0]  RST_CENTER = 32'd14000000;
  localparam logic [SPAN_W-1:0]    RST_SPAN   = 20'd200000;
  localparam logic [SPAN_W-1:0]    RST_WIDTH  = {RST_SPAN[SPAN_W-1:1], 1'b0};
  localparam logic [CENTER_W-1:0]  RST_START  =
      RST_CENTER - CENTER_W'(RST_SPAN[SPAN_W-1:1]);

  localparam logic [CFG_IDX_W-1:0] REG_CENTER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN   = 1'b1;

  typedef logic [3:0] step_t;

  localparam step_t ST_IDLE = 4'd0;
  localparam step_t ST_R0   = 4'd1;
  localparam step_t ST_R1   = 4'd2;
  localparam step_t ST_R2   = 4'd3;
  localparam step_t ST_W    = 4'd4;
  localparam step_t ST_S1   = 4'd5;
  localparam step_t ST_S2   = 4'd6;
  localparam step_t ST_S3   = 4'd7;
  localparam step_t ST_S4   = 4'd8;
  localparam step_t ST_S5   = 4'd9;
  localparam step_t ST_S6   = 4'd10;

  typedef enum logic [2:0] {
    J_NEXT,
    J_DISPATCH,
    J_EMIT,
    J_IDLE
  } jmp_t;

  typedef struct packed {
    jmp_t jmp;
    logic latch;
    logic div;
    logic rem;
    logic wr;
    logic rd;
    logic fill;
    logic sh;
    logic sm;
    logic em;
    logic em_rst;
  } ctrl_t;

  typedef struct packed {
    logic pt_last;
  } stat_t;

  function automatic ctrl_t uc_rom(step_t s);
    ctrl_t c;
    c = '{jmp: J_IDLE, default: 1'b0};
    case (s)
      ST_IDLE: c.jmp = J_DISPATCH;
      ST_R0: begin
        c.jmp   = J_NEXT;
        c.latch = 1'b1;
      end
      ST_R1: begin
        c.jmp = J_NEXT;
        c.div = 1'b1;
      end
      ST_R2: begin
        c.jmp    = J_IDLE;
        c.rem    = 1'b1;
        c.em_rst = 1'b1;
      end
      ST_W: begin
        c.jmp = J_NEXT;
        c.wr  = 1'b1;
      end
      ST_S1: begin
        c.jmp = J_NEXT;
        c.rd  = 1'b1;
      end
      ST_S2: begin
        c.jmp  = J_NEXT;
        c.rd   = 1'b1;
        c.fill = 1'b1;
      end
      ST_S3, ST_S4: begin
        c.jmp = J_NEXT;
        c.rd  = 1'b1;
        c.sh  = 1'b1;
      end
      ST_S5: begin
        c.jmp = J_NEXT;
        c.rd  = 1'b1;
        c.sh  = 1'b1;
        c.sm  = 1'b1;
      end
      ST_S6: begin
        c.jmp = J_EMIT;
        c.rd  = 1'b1;
        c.sh  = 1'b1;
        c.sm  = 1'b1;
        c.em  = 1'b1;
      end
      default: c.jmp = J_IDLE;
    endcase
    return c;
  endfunction

endpackage

[rtl/core/swr_seq.sv]
// Microcode sequencer: step counter, program ROM and jump logic.
module swr_seq
  import swr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  restart,
  input  logic  adv,
  input  stat_t stat,
  output ctrl_t ctrl,
  output logic  in_stall
);

  step_t step;
  step_t step_next;

  assign ctrl     = uc_rom(step);
  assign in_stall = (step != ST_IDLE);

  always_comb begin
    step_next = step;
    if (adv) begin
      case (ctrl.jmp)
        J_NEXT:     step_next = step + 4'd1;
        J_DISPATCH: begin
          if (in_valid) begin
            step_next = restart ? ST_R0 : ST_W;
          end
        end
        J_EMIT:     step_next = stat.pt_last ? ST_IDLE : step;
        J_IDLE:     step_next = ST_IDLE;
        default:    step_next = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

[rtl/core/swr_sweep_smoother.sv]
// Top level of the VSWR sweep smoother: config, sample store and datapath.
//
// A restart item clears the curve, latches the sweep from center_freq and span,
// divides the sweep width by NUM_POINTS with a reciprocal multiply followed by a
// remainder step, and returns one result. A sample item writes the store, then
// refills a five-tap window with one store read per cycle and emits one
// smoothed point per cycle while the output side does not stall, through the
// single read port of the sample store. A stalled output freezes the whole
// datapath; the next item is taken while the final result still waits in the
// output register. Config writes take effect at the next restart.
module swr_sweep_smoother
  import swr_pkg::*;
#(
  parameter int NUM_POINTS = 50
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 restart,
  input  logic [VSWR_W-1:0]    vswr_sample,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [IDX_W-1:0]     point_index,
  output logic [VSWR_W-1:0]    smoothed_vswr,
  output logic [FREQ_W-1:0]    next_freq,
  output logic                 last
);

  localparam int              AW      = $clog2(NUM_POINTS);
  localparam logic [AW-1:0]   LAST_PT = AW'(NUM_POINTS - 1);
  localparam logic [AW:0]     NP      = (AW + 1)'(NUM_POINTS);
  localparam logic [SPAN_W-1:0] QW_RST = SPAN_W'(RST_WIDTH / NUM_POINTS);
  localparam logic [AW-1:0]   RW_RST  = AW'(RST_WIDTH % NUM_POINTS);
  // floor(w / NUM_POINTS) == (w * RECIP) >> RECIP_SH for every 20-bit w
  localparam int              RECIP_SH = SPAN_W + AW;
  localparam int              QP_W     = 2 * SPAN_W + 1;
  localparam logic [SPAN_W:0] RECIP    =
      (SPAN_W + 1)'(((64'd1 << RECIP_SH) + 64'(NUM_POINTS - 1)) / 64'(NUM_POINTS));

  ctrl_t ctrl;
  stat_t stat;
  logic  adv;
  logic  in_accept;

  logic [CENTER_W-1:0] center_freq;
  logic [SPAN_W-1:0]   span;
  logic [CENTER_W-1:0] start_freq;
  logic [VSWR_W-1:0]   sample_q;

  logic [VSWR_W-1:0]     mem [NUM_POINTS];
  logic [NUM_POINTS-1:0] vld;
  logic [VSWR_W-1:0]     rd_q;
  logic                  rd_vld_q;
  logic [VSWR_W-1:0]     rdval;

  logic [AW-1:0] cp;
  logic [AW-1:0] rp;
  logic [AW-1:0] pt;
  logic [SPAN_W-1:0] q;
  logic [AW-1:0]     r;
  logic [AW:0]       rsum;

  logic [SPAN_W-1:0] dq;
  logic [AW-1:0]     drem;
  logic [AW:0]       wlow;
  logic [QP_W-1:0]   qprod;

  logic [VSWR_W-1:0]  tap [TAPS];
  logic [SUM_W-1:0]   tap_sum;
  logic [SUM_W-1:0]   sum_q;
  logic [2*SUM_W-1:0] prod;
  logic [SPAN_W-1:0]  half;

  assign in_accept = in_valid && !in_stall;
  assign adv = !(ctrl.em || ctrl.em_rst) || !out_valid || !out_stall;
  assign stat.pt_last  = (pt == LAST_PT);

  swr_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .restart  (restart),
    .adv      (adv),
    .stat     (stat),
    .ctrl     (ctrl),
    .in_stall (in_stall)
  );

  assign rdval = rd_vld_q ? rd_q : ONE_Q88;
  assign half  = {1'b0, span[SPAN_W-1:1]};
  assign rsum  = {1'b0, r} + {1'b0, drem};
  assign qprod = QP_W'(dq) * QP_W'(RECIP);
  assign prod  = (2 * SUM_W)'(sum_q) * (2 * SUM_W)'(DIV5_MUL);

  always_comb begin
    tap_sum = '0;
    for (int i = 0; i < TAPS; i++) begin
      tap_sum = tap_sum + SUM_W'(tap[i]);
    end
  end

  // config registers and sweep control state
  always_ff @(posedge clk) begin
    if (rst) begin
      center_freq <= RST_CENTER;
      span        <= RST_SPAN;
      start_freq  <= RST_START;
      vld         <= '0;
      cp          <= '0;
      rp          <= '0;
      pt          <= '0;
      q           <= '0;
      r           <= '0;
      dq          <= QW_RST;
      drem        <= RW_RST;
      wlow        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CENTER: center_freq <= cfg_data;
          REG_SPAN:   span <= cfg_data[SPAN_W-1:0];
          default:    center_freq <= center_freq;
        endcase
      end
      if (adv) begin
        if (ctrl.latch) begin
          start_freq <= (center_freq >= CENTER_W'(half)) ?
                        center_freq - CENTER_W'(half) : '0;
          vld  <= '0;
          cp   <= '0;
          q    <= '0;
          r    <= '0;
          dq   <= {span[SPAN_W-1:1], 1'b0};
          drem <= '0;
          wlow <= {span[AW:1], 1'b0};
        end
        if (ctrl.div) begin
          dq <= SPAN_W'(qprod >> RECIP_SH);
        end
        if (ctrl.rem) begin
          drem <= AW'(wlow - (AW + 1)'(dq[AW:0] * NP));
        end
        if (ctrl.wr) begin
          vld[cp] <= 1'b1;
          rp      <= '0;
          pt      <= '0;
          if (cp == LAST_PT) begin
            cp <= '0;
            q  <= '0;
            r  <= '0;
          end else begin
            cp <= cp + AW'(1);
            if (rsum >= NP) begin
              r <= AW'(rsum - NP);
              q <= q + dq + SPAN_W'(1);
            end else begin
              r <= rsum[AW-1:0];
              q <= q + dq;
            end
          end
        end
        if (ctrl.rd && (rp != LAST_PT)) begin
          rp <= rp + AW'(1);
        end
        if (ctrl.em) begin
          pt <= pt + AW'(1);
        end
      end
    end
  end

  // sample store
  always_ff @(posedge clk) begin
    if (adv && ctrl.wr) begin
      mem[cp] <= sample_q;
    end
    if (adv && ctrl.rd) begin
      rd_q     <= mem[rp];
      rd_vld_q <= vld[rp];
    end
  end

  // window taps and running sum
  always_ff @(posedge clk) begin
    if (in_accept) begin
      sample_q <= vswr_sample;
    end
    if (adv) begin
      if (ctrl.fill) begin
        for (int i = 0; i < TAPS; i++) begin
          tap[i] <= rdval;
        end
      end else if (ctrl.sh) begin
        for (int i = 0; i < TAPS - 1; i++) begin
          tap[i] <= tap[i+1];
        end
        tap[TAPS-1] <= rdval;
      end
      if (ctrl.sm) begin
        sum_q <= tap_sum;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((ctrl.em || ctrl.em_rst) && adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ctrl.em) begin
      point_index   <= IDX_W'(pt);
      smoothed_vswr <= prod[DIV5_SHIFT +: VSWR_W];
      next_freq     <= FREQ_W'(start_freq) + FREQ_W'(q);
      last          <= stat.pt_last;
    end else if (adv && ctrl.em_rst) begin
      point_index   <= '0;
      smoothed_vswr <= ONE_Q88;
      next_freq     <= FREQ_W'(start_freq);
      last          <= 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  a_cp_range: assert property (@(posedge clk) disable iff (rst) cp <= LAST_PT)
    else $error("sweep point out of range");
  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, r} < NP) && ({1'b0, drem} < NP))
    else $error("frequency fraction not below point count");
  a_idle_no_emit: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !(ctrl.em || ctrl.em_rst))
    else $error("emit while accepting input");
  a_emit_last: assert property (@(posedge clk) disable iff (rst)
    (adv && ctrl.em && stat.pt_last) |=> (out_valid && last && !in_stall))
    else $error("final point did not end the run");
`endif

endmodule

[sim/swr_checker.sv]
// Scoreboard for the VSWR sweep smoother: mirrors the curve and sweep, checks every result.
`timescale 1ns / 100ps

module swr_checker
  import swr_pkg::*;
#(
  parameter int NUM_POINTS = 50
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 restart,
  input  logic [VSWR_W-1:0]    vswr_sample,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [IDX_W-1:0]     point_index,
  input  logic [VSWR_W-1:0]    smoothed_vswr,
  input  logic [FREQ_W-1:0]    next_freq,
  input  logic                 last,
  output int                   errors,
  output int                   pending,
  output int                   checked
);

  localparam int MAX_REPORTS = 40;

  typedef struct {
    logic [IDX_W-1:0]  idx;
    logic [VSWR_W-1:0] vswr;
    logic [FREQ_W-1:0] freq;
    logic              lst;
  } curve_pt_t;

  curve_pt_t expected_curve[$];

  logic [VSWR_W-1:0]   readings [NUM_POINTS];
  int unsigned         sweep_pos;
  logic [FREQ_W-1:0]   start_hz;
  logic [SPAN_W:0]     width_hz;
  logic [CENTER_W-1:0] center_reg;
  logic [SPAN_W-1:0]   span_reg;

  int        err_cnt;
  int        chk_cnt;
  curve_pt_t pt;
  curve_pt_t got;
  logic [FREQ_W-1:0] tune_hz;

  initial begin
    errors  = 0;
    pending = 0;
    checked = 0;
    err_cnt = 0;
    chk_cnt = 0;
  end

  function automatic logic [VSWR_W-1:0] window_mean(int i);
    logic [SUM_W-1:0] acc;
    int j;
    acc = '0;
    for (int k = -2; k <= 2; k++) begin
      j = i + k;
      if (j < 0) j = 0;
      else if (j > NUM_POINTS - 1) j = NUM_POINTS - 1;
      acc = acc + SUM_W'(readings[j]);
    end
    return VSWR_W'(acc / 5);
  endfunction

  function automatic logic [FREQ_W-1:0] tune_freq(int unsigned pos);
    longint unsigned f;
    f = longint'(start_hz) + (longint'(width_hz) * longint'(pos)) / NUM_POINTS;
    return f[FREQ_W-1:0];
  endfunction

  task automatic clear_sweep();
    logic [CENTER_W-1:0] half;
    for (int i = 0; i < NUM_POINTS; i++) readings[i] = ONE_Q88;
    sweep_pos = 0;
    half      = CENTER_W'(span_reg >> 1);
    start_hz  = (center_reg >= half) ? FREQ_W'(center_reg - half) : '0;
    width_hz  = (SPAN_W + 1)'(half) << 1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      center_reg = RST_CENTER;
      span_reg   = RST_SPAN;
      clear_sweep();
      expected_curve.delete();
    end else begin
      // results first: an item accepted at this edge cannot have produced any yet
      if (out_valid && !out_stall) begin
        got = '{idx: point_index, vswr: smoothed_vswr, freq: next_freq, lst: last};
        if (expected_curve.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: unexpected result idx=%0d vswr=%0d freq=%0d last=%0b",
                     $time, got.idx, got.vswr, got.freq, got.lst);
        end else begin
          pt = expected_curve.pop_front();
          chk_cnt++;
          if (got.idx !== pt.idx || got.vswr !== pt.vswr ||
              got.freq !== pt.freq || got.lst !== pt.lst) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
              $display("%0t: mismatch exp idx=%0d vswr=%0d freq=%0d last=%0b, got idx=%0d vswr=%0d freq=%0d last=%0b",
                       $time, pt.idx, pt.vswr, pt.freq, pt.lst,
                       got.idx, got.vswr, got.freq, got.lst);
          end
        end
      end

      if (in_valid && !in_stall) begin
        if (restart) begin
          clear_sweep();
          expected_curve.push_back('{idx: '0, vswr: ONE_Q88, freq: start_hz, lst: 1'b1});
        end else begin
          readings[sweep_pos] = vswr_sample;
          sweep_pos = (sweep_pos == NUM_POINTS - 1) ? 0 : sweep_pos + 1;
          tune_hz   = tune_freq(sweep_pos);
          for (int i = 0; i < NUM_POINTS; i++)
            expected_curve.push_back('{idx: IDX_W'(i), vswr: window_mean(i), freq: tune_hz,
                                       lst: (i == NUM_POINTS - 1)});
        end
      end

      // register writes only latch at the next restart
      if (cfg_we) begin
        if (cfg_index == REG_CENTER) center_reg = cfg_data[CENTER_W-1:0];
        else if (cfg_index == REG_SPAN) span_reg = cfg_data[SPAN_W-1:0];
      end
    end
    errors  <= err_cnt;
    pending <= expected_curve.size();
    checked <= chk_cnt;
  end

endmodule

[sim/tb.sv]
// Testbench top for the VSWR sweep smoother: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;
  import swr_pkg::*;

  localparam int NUM_POINTS  = 50;
  localparam int RAND_ITEMS  = 170;
  localparam int CYCLE_LIMIT = 1000000;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 restart;
  logic [VSWR_W-1:0]    vswr_sample;
  logic                 out_valid;
  logic                 out_stall;
  logic [IDX_W-1:0]     point_index;
  logic [VSWR_W-1:0]    smoothed_vswr;
  logic [FREQ_W-1:0]    next_freq;
  logic                 last;

  int errors;
  int pending;
  int checked;

  int  cycle_cnt;
  int  n_items;
  int  n_restarts;
  int  n_cfg;
  int  stall_left;
  bit  quiet;

  swr_sweep_smoother #(.NUM_POINTS(NUM_POINTS)) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .restart      (restart),
    .vswr_sample  (vswr_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .point_index  (point_index),
    .smoothed_vswr(smoothed_vswr),
    .next_freq    (next_freq),
    .last         (last)
  );

  swr_checker #(.NUM_POINTS(NUM_POINTS)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .restart      (restart),
    .vswr_sample  (vswr_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .point_index  (point_index),
    .smoothed_vswr(smoothed_vswr),
    .next_freq    (next_freq),
    .last         (last),
    .errors       (errors),
    .pending      (pending),
    .checked      (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
      $display("TB_ERROR");
      $finish;
    end
  end

  // output back-pressure: mostly short stalls, a few long ones
  always @(posedge clk) begin
    int r;
    bit s;
    r = $urandom_range(0, 99);
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      s = 1'b1;
    end else if (quiet || r < 70) begin
      s = 1'b0;
    end else if (r < 95) begin
      stall_left = $urandom_range(0, 2);
      s = 1'b1;
    end else begin
      stall_left = $urandom_range(7, 19);
      s = 1'b1;
    end
    out_stall <= s;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [VSWR_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return '1;
      1:       return '0;
      2:       return ONE_Q88 + VSWR_W'($urandom_range(0, 511));
      default: return VSWR_W'($urandom());
    endcase
  endfunction

  function automatic logic [CENTER_W-1:0] pick_center();
    int r;
    r = $urandom_range(0, 7);
    case (r)
      0:       return '0;
      1:       return '1;
      2:       return CENTER_W'($urandom_range(0, 500000));
      default: return CENTER_W'($urandom());
    endcase
  endfunction

  function automatic logic [SPAN_W-1:0] pick_span();
    int r;
    r = $urandom_range(0, 7);
    case (r)
      0:       return SPAN_W'(2);
      1:       return SPAN_W'(1000000);
      2:       return SPAN_W'($urandom_range(2, 9));
      default: return SPAN_W'($urandom_range(2, 1000000));
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    n_cfg++;
  endtask

  task automatic write_sweep(input logic [CENTER_W-1:0] ctr, input logic [SPAN_W-1:0] spn);
    write_reg(REG_CENTER, CFG_W'(ctr));
    write_reg(REG_SPAN, CFG_W'(spn));
    cfg_we <= 1'b0;
  endtask

  task automatic send_item(input logic rs, input logic [VSWR_W-1:0] smp);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    restart     <= rs;
    vswr_sample <= smp;
    do @(posedge clk); while (in_stall);
    n_items++;
    if (rs) n_restarts++;
  endtask

  // block is idle once its last result has been taken
  task automatic settle(input int tail);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (tail) @(posedge clk);
  endtask

  initial begin
    int n_rand;
    int n_samp;
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    restart     = 1'b0;
    vswr_sample = '0;
    out_stall   = 1'b0;
    cycle_cnt   = 0;
    n_items     = 0;
    n_restarts  = 0;
    n_cfg       = 0;
    stall_left  = 0;
    quiet       = 1'b0;
    n_rand      = 0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sweep from reset values, first without a restart
    send_item(1'b0, '1);
    send_item(1'b0, '0);
    send_item(1'b1, '1);
    send_item(1'b0, '1);
    send_item(1'b0, '0);
    send_item(1'b0, 16'h8000);
    send_item(1'b0, 16'h0001);
    send_item(1'b0, 16'h00FF);
    settle(8);

    // start saturates at zero
    write_sweep('0, SPAN_W'(1000000));
    quiet = 1'b1;
    send_item(1'b1, pick_sample());
    send_item(1'b0, '1);
    send_item(1'b0, pick_sample());
    settle(8);

    // top of the center range, next_freq needs the 33rd bit
    write_sweep('1, SPAN_W'(1000000));
    quiet = 1'b0;
    send_item(1'b1, '0);
    send_item(1'b0, pick_sample());
    send_item(1'b0, '1);
    settle(8);

    write_sweep(CENTER_W'($urandom()), SPAN_W'(2));
    send_item(1'b1, pick_sample());
    send_item(1'b0, pick_sample());
    send_item(1'b0, pick_sample());
    settle(8);

    // odd span with center below the half span
    write_sweep(CENTER_W'(1000), SPAN_W'(999999));
    send_item(1'b1, pick_sample());
    send_item(1'b0, pick_sample());
    settle(8);

    // random sweeps: mostly restart then a run of samples, some without restart
    while (n_rand < RAND_ITEMS) begin
      if ($urandom_range(0, 3) != 0) write_sweep(pick_center(), pick_span());
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) != 0) begin
        send_item(1'b1, pick_sample());
        n_rand++;
      end
      n_samp = ($urandom_range(0, 4) == 0) ? $urandom_range(45, 60) : $urandom_range(1, 20);
      for (int i = 0; i < n_samp && n_rand < RAND_ITEMS; i++) begin
        if ($urandom_range(0, 39) == 0) send_item(1'b1, pick_sample());
        else send_item(1'b0, pick_sample());
        n_rand++;
      end
      settle(8);
    end

    settle(100);
    $display("%0d items (%0d restarts), %0d register writes, %0d results checked",
             n_items, n_restarts, n_cfg, checked);
    $display("sweeps over clamped ends, wrap of the point index and saturated start");
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d errors, %0d results missing", errors, pending);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
